[sv/integer_square_root_defines.svh]
// Assertion macros for the integer square root checker.
// Needs a clock named clk and an active-low reset named arst_n in the scope of use.
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isr check failed");

// Next-cycle implication, checked outside reset.
`define ISR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isr check failed");

`endif

[sv/isr_pkg.sv]
// Shared helpers for the integer square root block.
// No dependencies.
`timescale 1ns / 1ps

package isr_pkg;

	// Reset value of the signed mode register.
	localparam logic SIGNED_MODE_RESET = 1'b0;

	// Number of root bits for an operand of the given width.
	function automatic int root_width(input int data_width);
		return (data_width + 1) >> 1;
	endfunction

	// Width rounded up to whole bytes.
	function automatic int byte_width(input int bits);
		return ((bits + 7) >> 3) << 3;
	endfunction

endpackage

[sv/isr_cell.sv]
// One digit step of the square root chain: takes two radicand bits, decides one root bit.
// Depends on nothing but the clock and reset; instantiated by integer_square_root.
`timescale 1ns / 1ps

module isr_cell #(
	parameter int ROOT_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  logic [2*ROOT_W-1:0]   rad_i,
	input  logic [ROOT_W:0]       rem_i,
	input  logic [ROOT_W-1:0]     root_i,
	output logic                  vld_o,
	output logic [2*ROOT_W-1:0]   rad_o,
	output logic [ROOT_W:0]       rem_o,
	output logic [ROOT_W-1:0]     root_o
);

	localparam int RAD_W = 2 * ROOT_W;

	logic                vld_q;
	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;

	logic [ROOT_W+2:0]   rem_sh;
	logic [ROOT_W+2:0]   trial;
	logic [ROOT_W+2:0]   diff;
	logic                ge;
	logic [ROOT_W:0]     root_ext;

	always_comb begin
		rem_sh   = {rem_i, rad_i[RAD_W-1 -: 2]};
		trial    = {1'b0, root_i, 2'b01};
		ge       = (rem_sh >= trial);
		diff     = rem_sh - trial;
		root_ext = {root_i, ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// The partial remainder stays below twice the root plus one, so RW+1 bits hold it.
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_i << 2;
			rem_q  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= root_ext[ROOT_W-1:0];
		end
	end

	assign vld_o  = vld_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule

[sv/integer_square_root.sv]
// Structure: one registered cell per root bit between input transfer and result.
// Throughput: one operand per cycle unless stalled; the whole cell chain advances together
// whenever the output register is empty or being taken, and s_tready is high exactly then.
// Reset: arst_n clears all valid flags and sets signed mode to unsigned (0).
// Config: cfg_ready is always high; signed mode is sampled as each operand enters.
`timescale 1ns / 1ps

module integer_square_root #(
	parameter int DATA_WIDTH = 32,
	localparam int ROOT_W = isr_pkg::root_width(DATA_WIDTH),
	localparam int S_W    = isr_pkg::byte_width(DATA_WIDTH),
	localparam int M_W    = isr_pkg::byte_width(ROOT_W)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data,    // signed_mode
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [S_W-1:0]  s_tdata,     // value
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [M_W-1:0]  m_tdata      // root
);

	localparam int RAD_W = 2 * ROOT_W;

	logic                 signed_mode_q;
	logic                 en;
	logic [DATA_WIDTH-1:0] value;
	logic                 neg;

	logic                 vld_c  [ROOT_W+1];
	logic [RAD_W-1:0]     rad_c  [ROOT_W+1];
	logic [ROOT_W:0]      rem_c  [ROOT_W+1];
	logic [ROOT_W-1:0]    root_c [ROOT_W+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= isr_pkg::SIGNED_MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	assign en       = !vld_c[ROOT_W] || m_tready;
	assign s_tready = en;

	// A negative operand in signed mode enters the chain as zero, which yields root zero.
	assign value     = s_tdata[DATA_WIDTH-1:0];
	assign neg       = signed_mode_q && value[DATA_WIDTH-1];
	assign vld_c[0]  = s_tvalid;
	assign rad_c[0]  = neg ? '0 : RAD_W'(value);
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		isr_cell #(
			.ROOT_W(ROOT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_c[i]),
			.rad_i  (rad_c[i]),
			.rem_i  (rem_c[i]),
			.root_i (root_c[i]),
			.vld_o  (vld_c[i+1]),
			.rad_o  (rad_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.root_o (root_c[i+1])
		);
	end

	assign m_tvalid = vld_c[ROOT_W];
	assign m_tdata  = M_W'(root_c[ROOT_W]);

endmodule

[sv/isr_checker.sv]
// Port-level checks for the integer square root block, bound to the top level.
// Depends on isr_pkg and integer_square_root_defines.svh.
`timescale 1ns / 1ps
`include "integer_square_root_defines.svh"

module isr_checker #(
	parameter int DATA_WIDTH = 32,
	localparam int ROOT_W = isr_pkg::root_width(DATA_WIDTH),
	localparam int M_W    = isr_pkg::byte_width(ROOT_W)
) (
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic            s_tready,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [M_W-1:0]  m_tdata
);

	// A stalled result stays offered.
	`ISR_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	// A stalled result keeps its data.
	`ISR_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	// The chain only stops for a full, unread output.
	`ISR_ASSERT_IMPL(a_ready_free, !m_tvalid || m_tready, s_tready)
	// Bits above the root width are zero filler.
	`ISR_ASSERT_IMPL(a_root_range, m_tvalid, (m_tdata >> ROOT_W) == '0)
	// A register write is never held off.
	`ISR_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind integer_square_root isr_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_isr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
